FILE: hdl/cmme_pkg.sv
package cmme_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CHAN_W  = 8;

  typedef struct packed {
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    logic [MAG_W-1:0]          pk;
    logic [TIME_W-1:0]         lo_time;
    logic [TIME_W-1:0]         hi_time;
    logic [TIME_W-1:0]         pk_time;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Magnitude of a signed sample; the most negative value saturates.
  function automatic logic [MAG_W-1:0] magnitude(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] neg;
    neg = VALUE_W'(-v);
    if (!v[VALUE_W-1]) begin
      magnitude = v[MAG_W-1:0];
    end else if (v[MAG_W-1:0] == '0) begin
      magnitude = '1;
    end else begin
      magnitude = neg[MAG_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/cmme_ram.sv
module cmme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/channel_min_max_envelope_core.sv
// An accepted input beat is registered into stage 1, then into the output registers.
// Throughput: one beat per cycle while out_ready holds; the envelope memory is read
// on accept and written back as the beat leaves stage 1, with forwarding of the last write.
// Reset clears the per-channel seen bits and record_times;
// there is no clearing pass, so input is accepted right after reset.
module channel_min_max_envelope_core #(
  parameter int unsigned CHANNELS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cmme_pkg::CHAN_W-1:0]        channel,
  input  logic signed [cmme_pkg::VALUE_W-1:0] sample_value,
  input  logic [cmme_pkg::TIME_W-1:0]        sample_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cmme_pkg::CHAN_W-1:0]        out_channel,
  output logic signed [cmme_pkg::VALUE_W-1:0] lowest,
  output logic signed [cmme_pkg::VALUE_W-1:0] highest,
  output logic [cmme_pkg::MAG_W-1:0]         peak_magnitude,
  output logic [cmme_pkg::TIME_W-1:0]        lowest_time,
  output logic [cmme_pkg::TIME_W-1:0]        highest_time,
  output logic [cmme_pkg::TIME_W-1:0]        peak_time
);

  localparam int unsigned REACH = 1 << cmme_pkg::CHAN_W;
  localparam int unsigned DEPTH = (CHANNELS < REACH) ? CHANNELS : REACH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic record_times;

  logic                               s1_valid;
  logic                               s1_in_range;
  logic [AW-1:0]                      s1_addr;
  logic [cmme_pkg::CHAN_W-1:0]        s1_channel;
  logic signed [cmme_pkg::VALUE_W-1:0] s1_value;
  logic [cmme_pkg::MAG_W-1:0]         s1_mag;
  logic [cmme_pkg::TIME_W-1:0]        s1_time;

  logic [DEPTH-1:0]                   seen;
  logic                               fwd_valid;
  logic [AW-1:0]                      fwd_addr;
  cmme_pkg::entry_t                   fwd_data;

  logic                               in_range;
  logic [AW-1:0]                      in_addr;
  logic                               accept;
  logic                               s1_adv;
  logic                               wr_en;
  logic [cmme_pkg::ENTRY_W-1:0]       rd_raw;
  cmme_pkg::entry_t                   cur;
  cmme_pkg::entry_t                   upd;
  logic                               lt_min;
  logic                               gt_max;

  assign in_range = (32'(channel) < CHANNELS);
  assign in_addr  = in_range ? channel[AW-1:0] : '0;
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;
  assign wr_en    = s1_adv && s1_in_range;

  cmme_ram #(
    .WIDTH (cmme_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (upd),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : cmme_pkg::entry_t'(rd_raw);
    lt_min = $signed(s1_value) < $signed(cur.lo);
    gt_max = $signed(s1_value) > $signed(cur.hi);
    upd = cur;
    if (!seen[s1_addr]) begin
      upd.lo      = s1_value;
      upd.hi      = s1_value;
      upd.pk      = s1_mag;
      upd.lo_time = s1_time;
      upd.hi_time = s1_time;
      upd.pk_time = s1_time;
    end else begin
      if (lt_min) begin
        upd.lo      = s1_value;
        upd.lo_time = s1_time;
      end else if (gt_max) begin
        upd.hi      = s1_value;
        upd.hi_time = s1_time;
      end
      if ((lt_min || gt_max) && s1_mag > cur.pk) begin
        upd.pk      = s1_mag;
        upd.pk_time = s1_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_times <= 1'b0;
      s1_valid     <= 1'b0;
      seen         <= '0;
      fwd_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        record_times <= cfg_wdata;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        seen[s1_addr] <= 1'b1;
        fwd_valid     <= 1'b1;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
      s1_channel  <= channel;
      s1_value    <= sample_value;
      s1_mag      <= cmme_pkg::magnitude(sample_value);
      s1_time     <= record_times ? sample_time : '0;
    end
    if (wr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= upd;
    end
    if (s1_adv) begin
      out_channel <= s1_channel;
      if (s1_in_range) begin
        lowest         <= upd.lo;
        highest        <= upd.hi;
        peak_magnitude <= upd.pk;
        lowest_time    <= upd.lo_time;
        highest_time   <= upd.hi_time;
        peak_time      <= upd.pk_time;
      end else begin
        lowest         <= '0;
        highest        <= '0;
        peak_magnitude <= '0;
        lowest_time    <= '0;
        highest_time   <= '0;
        peak_time      <= '0;
      end
    end
  end

endmodule
